### rtl/core/stick_slip_friction_step_core_macros.svh
// Assertion macros for the friction step core.
`ifndef STICK_SLIP_FRICTION_STEP_CORE_MACROS_SVH
`define STICK_SLIP_FRICTION_STEP_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SSF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSF_ASSERT_IMP(lbl, ante, cons)
`define SSF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/core/ssf_pkg.sv
package ssf_pkg;

    localparam int NUM_LANES = 3;

    localparam logic [2:0] REG_STATIC_SLACK  = 3'd0;
    localparam logic [2:0] REG_KINETIC_SLACK = 3'd1;
    localparam logic [2:0] REG_STIFFNESS     = 3'd2;
    localparam logic [2:0] REG_DAMPING       = 3'd3;
    localparam logic [2:0] REG_INV_TSTEP     = 3'd4;

    localparam logic [30:0] ONE_Q16  = 31'h0001_0000;
    localparam logic [30:0] ZERO_Q16 = 31'h0;

    typedef struct packed {
        logic load;
        logic square;
        logic mulr;
        logic div_init;
        logic div_step;
        logic commit;
        logic force1;
        logic force2;
        logic force3;
    } lane_ctrl_t;

endpackage

### rtl/core/ssf_sqrt.sv
module ssf_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [66:0] radicand,
    output logic [32:0] root,
    output logic        done
);
    import ssf_pkg::*;

    logic [67:0] rad_reg, rad_next;
    logic [35:0] rem_reg, rem_next;
    logic [33:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    // one result bit per cycle, two radicand bits shifted in each time
    always_comb
    begin
        rem_sh    = {rem_reg[33:0], rad_reg[67:66]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = {1'b0, radicand};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[65:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[32:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd33)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg[32:0];
    assign done = done_reg;

endmodule

### rtl/core/ssf_lane.sv
module ssf_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  ssf_pkg::lane_ctrl_t ctrl,
    input  logic signed [31:0]  step,
    input  logic                pull,
    input  logic [30:0]         radius,
    input  logic [32:0]         norm,
    input  logic                damp_en,
    input  logic [30:0]         stiff,
    input  logic [30:0]         dampc,
    input  logic [30:0]         inv_ts,
    output logic [64:0]         sq,
    output logic [31:0]         force_val
);
    import ssf_pkg::*;

    logic signed [31:0] hist_reg, inc_reg;
    logic signed [32:0] sum_reg;
    logic [64:0]        sq_reg;
    logic [62:0]        prod_reg;
    logic [33:0]        rem_reg;
    logic [30:0]        dvd_reg, quo_reg;
    logic [62:0]        e_reg, d1_reg, dlo_reg;
    logic [61:0]        dhi_reg;
    logic [31:0]        force_reg;

    logic [32:0]        sum_mag;
    logic [31:0]        hist_mag, inc_mag;
    logic [33:0]        rem_sh;
    logic               div_ge;
    logic [30:0]        q;
    logic signed [31:0] hist_new;
    logic [95:0]        e_full, d_full, m;
    logic               neg;
    logic [63:0]        x;
    logic [31:0]        force_new;

    always_comb
    begin
        sum_mag  = sum_reg[32] ? 33'(-sum_reg) : 33'(sum_reg);
        hist_mag = hist_reg[31] ? 32'(-hist_reg) : 32'(hist_reg);
        inc_mag  = inc_reg[31] ? 32'(-inc_reg) : 32'(inc_reg);
        rem_sh   = {rem_reg[32:0], dvd_reg[30]};
        div_ge   = rem_sh >= {1'b0, norm};
        // zero norm only with zero radius: history collapses to zero
        q        = (norm == '0) ? '0 : quo_reg;
        if (!pull)
            hist_new = sum_reg[31:0];
        else if (sum_reg[32])
            hist_new = 32'(-$signed({1'b0, q}));
        else
            hist_new = $signed({1'b0, q});

        e_full = {17'b0, e_reg, 16'b0};
        d_full = {2'b0, dhi_reg, 32'b0} + {33'b0, dlo_reg};
        if (hist_reg[31] == inc_reg[31])
        begin
            m   = e_full + d_full;
            neg = hist_reg[31];
        end
        else if (e_full >= d_full)
        begin
            m   = e_full - d_full;
            neg = hist_reg[31];
        end
        else
        begin
            m   = d_full - e_full;
            neg = inc_reg[31];
        end
        x = m[95:32];
        if (neg)
            force_new = (x > 64'h8000_0000) ? 32'h8000_0000 : 32'(-x);
        else
            force_new = (x > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : x[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hist_reg <= '0;
        else if (ctrl.commit)
            hist_reg <= hist_new;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            inc_reg <= step;
            sum_reg <= 33'(hist_reg) + 33'(step);
        end
        if (ctrl.square)
            sq_reg <= 65'(66'(sum_mag) * 66'(sum_mag));
        if (ctrl.mulr)
            prod_reg <= 63'(64'(sum_mag) * 64'(radius));
        if (ctrl.div_init)
        begin
            rem_reg <= {2'b00, prod_reg[62:31]};
            dvd_reg <= prod_reg[30:0];
            quo_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= div_ge ? rem_sh - {1'b0, norm} : rem_sh;
            dvd_reg <= {dvd_reg[29:0], 1'b0};
            quo_reg <= {quo_reg[29:0], div_ge};
        end
        if (ctrl.force1)
        begin
            e_reg  <= 63'(hist_mag * 63'(stiff));
            d1_reg <= damp_en ? 63'(inc_mag * 63'(dampc)) : '0;
        end
        if (ctrl.force2)
        begin
            dlo_reg <= 63'(d1_reg[31:0] * 63'(inv_ts));
            dhi_reg <= 62'(d1_reg[62:32] * 62'(inv_ts));
        end
        if (ctrl.force3)
            force_reg <= force_new;
    end

    assign sq        = sq_reg;
    assign force_val = force_reg;

endmodule

### rtl/core/stick_slip_friction_step_core.sv
// Stick-slip friction step, three axes, Q16.16.
// Input channel s_axis carries one displacement increment word (x, y, z).
// Output channel m_axis returns one force word per input word, with the
// mode after the step on tuser (1 = kinetic).
// Configuration: cfg_wr_en with cfg_index 0..4 writes static slack,
// kinetic slack, stiffness, damping and inverse time step; other indexes
// are ignored. Write only while the core is idle.
// One lane per axis forms the sum, square, rescale quotient and force; a
// merge stage adds the squares and decides the mode.
// Without a pull-back a word passes the square, sum, compare, commit and
// three force states; with one it also waits for the square root and then
// runs the lane dividers. One word is in work at a time; s_axis_tready
// is high whenever no word is in work, even while a result waits, so a new
// word is accepted only once the previous result has gone to the output register.
// If the receiver stalls, the finished result waits in the output
// register and the next word still runs until its own result is ready.
// Reset clears history to zero, mode to static, registers to defaults.
`include "stick_slip_friction_step_core_macros.svh"
module stick_slip_friction_step_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // step_x, step_y, step_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // force_x, force_y, force_z
    output logic        m_axis_tuser,   // kinetic_mode
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    import ssf_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQ     = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_SQRT   = 4'd4;
    localparam logic [3:0] S_MULR   = 4'd5;
    localparam logic [3:0] S_DINIT  = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_COMMIT = 4'd8;
    localparam logic [3:0] S_F1     = 4'd9;
    localparam logic [3:0] S_F2     = 4'd10;
    localparam logic [3:0] S_F3     = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [30:0] static_slack_reg, kinetic_slack_reg, stiff_reg, damp_reg, inv_ts_reg;
    logic [3:0]  state_reg, state_next;
    logic        sliding_reg, sliding_next;
    logic        pull_reg, pull_next;
    logic [30:0] radius_reg;
    logic [61:0] lim_reg;
    logic [66:0] sq_tot_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        m_valid_reg;
    logic [95:0] m_data_reg;
    logic        m_user_reg;

    lane_ctrl_t  lane_ctrl;
    logic [64:0] lane_sq [NUM_LANES];
    logic [31:0] lane_force [NUM_LANES];
    logic        in_accept, out_load, sqrt_start, sqrt_done;
    logic [32:0] norm;
    logic [30:0] radius_sel;
    logic        over;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_load   = (state_reg == S_DONE) && (!m_valid_reg || m_axis_tready);
    assign radius_sel = sliding_reg ? kinetic_slack_reg : static_slack_reg;
    assign over       = sliding_reg ? (sq_tot_reg >= 67'(lim_reg))
                                    : (sq_tot_reg > 67'(lim_reg));

    always_comb
    begin
        lane_ctrl          = '0;
        lane_ctrl.load     = in_accept;
        lane_ctrl.square   = state_reg == S_SQ;
        lane_ctrl.mulr     = state_reg == S_MULR;
        lane_ctrl.div_init = state_reg == S_DINIT;
        lane_ctrl.div_step = state_reg == S_DIV;
        lane_ctrl.commit   = state_reg == S_COMMIT;
        lane_ctrl.force1   = state_reg == S_F1;
        lane_ctrl.force2   = state_reg == S_F2;
        lane_ctrl.force3   = state_reg == S_F3;
    end

    always_comb
    begin
        state_next   = state_reg;
        sliding_next = sliding_reg;
        pull_next    = pull_reg;
        cnt_next     = cnt_reg;
        sqrt_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:   if (in_accept) state_next = S_SQ;
            S_SQ:     state_next = S_SUM;
            S_SUM:    state_next = S_CMP;
            S_CMP:
            begin
                // static: strictly above turns kinetic; kinetic: below returns static
                pull_next    = over;
                sliding_next = over;
                if (over)
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
                else
                    state_next = S_COMMIT;
            end
            S_SQRT:   if (sqrt_done) state_next = S_MULR;
            S_MULR:   state_next = S_DINIT;
            S_DINIT:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30) state_next = S_COMMIT;
            end
            S_COMMIT: state_next = S_F1;
            S_F1:     state_next = S_F2;
            S_F2:     state_next = S_F3;
            S_F3:     state_next = S_DONE;
            S_DONE:   if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            sliding_reg       <= 1'b0;
            pull_reg          <= 1'b0;
            cnt_reg           <= '0;
            m_valid_reg       <= 1'b0;
            static_slack_reg  <= ONE_Q16;
            kinetic_slack_reg <= ONE_Q16;
            stiff_reg         <= ONE_Q16;
            damp_reg          <= ZERO_Q16;
            inv_ts_reg        <= ONE_Q16;
        end
        else
        begin
            state_reg   <= state_next;
            sliding_reg <= sliding_next;
            pull_reg    <= pull_next;
            cnt_reg     <= cnt_next;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_STATIC_SLACK:  static_slack_reg  <= cfg_data;
                    REG_KINETIC_SLACK: kinetic_slack_reg <= cfg_data;
                    REG_STIFFNESS:     stiff_reg         <= cfg_data;
                    REG_DAMPING:       damp_reg          <= cfg_data;
                    REG_INV_TSTEP:     inv_ts_reg        <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SQ)
        begin
            radius_reg <= radius_sel;
            lim_reg    <= 62'(radius_sel * 62'(radius_sel));
        end
        if (state_reg == S_SUM)
            sq_tot_reg <= 67'(lane_sq[0]) + 67'(lane_sq[1]) + 67'(lane_sq[2]);
        if (out_load)
        begin
            m_data_reg <= {lane_force[2], lane_force[1], lane_force[0]};
            m_user_reg <= sliding_reg;
        end
    end

    ssf_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_tot_reg),
        .root     (norm),
        .done     (sqrt_done)
    );

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        ssf_lane u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (lane_ctrl),
            .step      ($signed(s_axis_tdata[32*i +: 32])),
            .pull      (pull_reg),
            .radius    (radius_reg),
            .norm      (norm),
            .damp_en   (!sliding_reg),
            .stiff     (stiff_reg),
            .dampc     (damp_reg),
            .inv_ts    (inv_ts_reg),
            .sq        (lane_sq[i]),
            .force_val (lane_force[i])
        );
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `SSF_ASSERT_NXT(a_accept_starts, in_accept, state_reg == S_SQ)
    `SSF_ASSERT_IMP(a_sqrt_only_pull, state_reg == S_SQRT, pull_reg && sliding_reg)
    `SSF_ASSERT_NXT(a_mode_on_out, out_load, m_axis_tvalid && (m_axis_tuser == sliding_reg))

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import ssf_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic        kin;
    } force_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;

    // predictor state
    logic [30:0] slack_s, slack_k, stiff, damp, inv_dt;
    logic signed [31:0] hist [3];
    logic        slipping;

    force_word_t expected_forces [$];
    int          errors = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;

    stick_slip_friction_step_core DUT (.*);

    always #2 clk = ~clk;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [34:0] isqrt(input logic [127:0] s);
        logic [34:0] r;
        logic [34:0] c;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (35'd1 << b);
            if (128'(c) * 128'(c) <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] pull_back(input logic signed [63:0] s,
        input logic [30:0] radius, input logic [34:0] norm);
        logic [127:0] q;
        q = '0;
        if (norm != 0)
            q = (128'(mag64(s)) * 128'(radius)) / 128'(norm);
        if (s < 0)
            return q > 128'h8000_0000 ? 32'sh8000_0000 : 32'(-q);
        return q > 128'h7FFF_FFFF ? 32'sh7FFF_FFFF : 32'(q);
    endfunction

    function automatic logic [31:0] axis_force(input logic signed [31:0] h,
        input logic signed [31:0] inc, input bit with_damping);
        logic [127:0] e, d, m, t;
        bit           en, dn, neg;
        en = h < 0;
        dn = inc < 0;
        e = (128'(mag64(64'(h))) * 128'(stiff)) << 16;
        d = with_damping ? 128'(mag64(64'(inc))) * 128'(damp) * 128'(inv_dt) : '0;
        if (en == dn) begin
            m = e + d;
            neg = en;
        end else if (e >= d) begin
            m = e - d;
            neg = en;
        end else begin
            m = d - e;
            neg = dn;
        end
        t = m >> 32;
        if (neg)
            return t > 128'h8000_0000 ? 32'h8000_0000 : 32'(-t);
        return t > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(t);
    endfunction

    function automatic force_word_t predict_force(input logic [95:0] word);
        logic signed [31:0]  inc [3];
        logic signed [63:0]  sum [3];
        logic [127:0]        sq;
        logic [127:0]        lim;
        logic [30:0]         radius;
        bit                  pull;
        logic [34:0]         norm;
        force_word_t         r;
        sq = '0;
        pull = 1'b0;
        for (int i = 0; i < 3; i++) begin
            inc[i] = word[32*i +: 32];
            sum[i] = 64'(hist[i]) + 64'(inc[i]);
            sq += 128'(mag64(sum[i])) * 128'(mag64(sum[i]));
        end
        radius = slipping ? slack_k : slack_s;
        lim = 128'(radius) * 128'(radius);
        if (!slipping) begin
            if (sq > lim) begin
                pull = 1'b1;
                slipping = 1'b1;
            end
        end else if (sq >= lim)
            pull = 1'b1;
        else
            slipping = 1'b0;
        norm = pull ? isqrt(sq) : '0;
        for (int i = 0; i < 3; i++) begin
            hist[i] = pull ? pull_back(sum[i], radius, norm) : 32'(sum[i]);
        end
        r.fx = axis_force(hist[0], inc[0], !slipping);
        r.fy = axis_force(hist[1], inc[1], !slipping);
        r.fz = axis_force(hist[2], inc[2], !slipping);
        r.kin = slipping;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
        input logic [31:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want,
                 words_checked);
        errors++;
    endtask

    // check each accepted result against the oldest prediction
    always @(posedge clk) begin
        force_word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_forces.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[31:0], '0);
            end else begin
                w = expected_forces.pop_front();
                if (m_axis_tdata[31:0] !== w.fx)
                    report_mismatch("force_x", m_axis_tdata[31:0], w.fx);
                if (m_axis_tdata[63:32] !== w.fy)
                    report_mismatch("force_y", m_axis_tdata[63:32], w.fy);
                if (m_axis_tdata[95:64] !== w.fz)
                    report_mismatch("force_z", m_axis_tdata[95:64], w.fz);
                if (m_axis_tuser !== w.kin)
                    report_mismatch("kinetic_mode", 32'(m_axis_tuser), 32'(w.kin));
            end
            words_checked++;
        end
    end

    // receiver stalls
    always @(negedge clk)
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 9);

    // watchdog on cycles with no handshake
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (rst_n && (s_axis_tvalid || expected_forces.size() != 0)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_step(input logic [31:0] x, input logic [31:0] y,
        input logic [31:0] z);
        if (!calm) begin
            while ($urandom_range(99) < 9)
                @(negedge clk);
        end
        s_axis_tdata <= {z, y, x};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_forces.push_back(predict_force({z, y, x}));
        words_sent++;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        // drop valid after the handshake; the core is busy with this word anyway
        @(negedge clk);
    endtask

    task automatic drain;
        while (expected_forces.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_STATIC_SLACK:  slack_s = val;
            REG_KINETIC_SLACK: slack_k = val;
            REG_STIFFNESS:     stiff = val;
            REG_DAMPING:       damp = val;
            REG_INV_TSTEP:     inv_dt = val;
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [30:0] ss, input logic [30:0] ks,
        input logic [30:0] k, input logic [30:0] c, input logic [30:0] dt);
        drain();
        write_reg(REG_STATIC_SLACK, ss);
        write_reg(REG_KINETIC_SLACK, ks);
        write_reg(REG_STIFFNESS, k);
        write_reg(REG_DAMPING, c);
        write_reg(REG_INV_TSTEP, dt);
    endtask

    function automatic logic [31:0] rand_step(input int scale);
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h8000_0000 | ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h0);
            default: return 32'($signed($urandom_range(2 * scale)) - scale);
        endcase
    endfunction

    task automatic test_defaults;
        send_step(32'h0, 32'h0, 32'h0);
        send_step(32'h0000_8000, 32'h0, 32'h0);
        send_step(32'h0002_0000, 32'h0, 32'h0);
        send_step(32'h0, 32'h0001_0000, 32'h0);
        send_step(32'hFFFF_0000, 32'hFFFF_0000, 32'h0);
        send_step(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    task automatic test_extreme_gains;
        set_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                31'h7FFF_FFFF);
        send_step(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
        send_step(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_step(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        // zero slack collapses history; unused index is ignored
        set_all(31'h0, 31'h0, ONE_Q16, ONE_Q16, ZERO_Q16);
        write_reg(3'd7, 31'h1234);
        write_reg(3'd5, 31'h1);
        send_step(32'h0, 32'h0, 32'h0);
        send_step(32'h0000_0100, 32'h0, 32'h0);
        send_step(32'h0, 32'h0, 32'h0);
        send_step(32'h0, 32'h0, 32'h0000_0001);
        set_all(31'h0, 31'h0, 31'h0, ZERO_Q16, ONE_Q16);
        send_step(32'h0000_0001, 32'h0, 32'h0);
    endtask

    task automatic test_random_steps(input int count);
        int scale;
        for (int n = 0; n < count; n++) begin
            if (n % 125 == 0) begin
                scale = 1 << $urandom_range(14, 20);
                set_all(31'($urandom_range(1, 1 << $urandom_range(14, 22))),
                        31'($urandom_range(1, 1 << $urandom_range(14, 22))),
                        31'($urandom_range(0, 1 << $urandom_range(12, 30))),
                        31'($urandom_range(0, 1 << $urandom_range(12, 30))),
                        31'($urandom_range(1, 1 << $urandom_range(12, 30))));
            end
            calm = (n >= 250 && n < 350);
            if ($urandom_range(9) < 2)
                send_step(rand_step(scale), 32'h0, 32'h0);
            else
                send_step(rand_step(scale), rand_step(scale), rand_step(scale));
        end
        calm = 1'b0;
    endtask

    initial begin
        slack_s = ONE_Q16;
        slack_k = ONE_Q16;
        stiff = ONE_Q16;
        damp = ZERO_Q16;
        inv_dt = ONE_Q16;
        for (int i = 0; i < 3; i++)
            hist[i] = '0;
        slipping = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_defaults();
        test_extreme_gains();
        test_random_steps(750);
        drain();
        $display("sent %0d increment words, checked %0d force words", words_sent,
                 words_checked);
        $display("covered default, extreme and random gains, zero slack, scalar steps");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ssf_pkg.sv
rtl/core/ssf_sqrt.sv
rtl/core/ssf_lane.sv
rtl/core/stick_slip_friction_step_core.sv
tb/testbench.sv
